>>> sv/rtt_pkg.sv
// Shared types and constants for the RTT retransmit timeout estimator.
package rtt_pkg;

   // Field and state widths
   localparam int unsigned SampleWidth = 24;
   localparam int unsigned WeightWidth = 16;
   localparam int unsigned StateWidth  = 40;
   localparam int unsigned HalfWidth   = 20;
   localparam int unsigned ProdWidth   = WeightWidth + HalfWidth;
   localparam int unsigned AccWidth    = 58;
   localparam int unsigned OutWidth    = 32;
   localparam int unsigned IndexWidth  = 3;

   // Weight register indexes
   localparam logic [IndexWidth-1:0] RegSmoothKeep   = 3'd0;
   localparam logic [IndexWidth-1:0] RegSmoothSample = 3'd1;
   localparam logic [IndexWidth-1:0] RegDevKeep      = 3'd2;
   localparam logic [IndexWidth-1:0] RegDevDiff      = 3'd3;
   localparam logic [IndexWidth-1:0] RegTimeoutSmooth = 3'd4;
   localparam logic [IndexWidth-1:0] RegTimeoutDev   = 3'd5;

   // Weight reset values, unsigned Q4.12
   localparam logic [WeightWidth-1:0] DefSmoothKeep    = 16'd3584;
   localparam logic [WeightWidth-1:0] DefSmoothSample  = 16'd512;
   localparam logic [WeightWidth-1:0] DefDevKeep       = 16'd3072;
   localparam logic [WeightWidth-1:0] DefDevDiff       = 16'd1024;
   localparam logic [WeightWidth-1:0] DefTimeoutSmooth = 16'd4096;
   localparam logic [WeightWidth-1:0] DefTimeoutDev    = 16'd16384;

   // Rounding constants for the accumulator
   localparam logic [AccWidth-1:0] RoundState   = 58'd2048;
   localparam logic [AccWidth-1:0] RoundTimeout = 58'd524288;

   // Input commands
   localparam logic CmdInit   = 1'b0;
   localparam logic CmdUpdate = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SM_LO, ST_SM_HI, ST_SM_ACC, ST_SM_WR,
      ST_DV_LO, ST_DV_HI, ST_DV_ACC, ST_DV_WR,
      ST_TO_LO, ST_TO_HI, ST_TO_ACC, ST_TO_WR,
      ST_OUT_LD
   } state_type;

   // Which blend the shared multipliers work on
   typedef enum logic [1:0] {
      PH_SMOOTH,
      PH_DEV,
      PH_TIMEOUT
   } phase_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD_ROUND,
      ACC_ADD_LO,
      ACC_ADD_HI
   } acc_op_type;

   // Controller to datapath commands
   typedef struct packed {
      phase_type  phase;
      logic       half_hi;
      acc_op_type acc_op;
      logic       load_init;
      logic       load_sample;
      logic       wr_smooth;
      logic       wr_dev;
      logic       wr_timeout;
      logic       load_out;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

>>> sv/rtt_ctrl.sv
// Sequencing controller for the RTT estimator.
module rtt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_command,
   output logic               req_stall,
   input  rtt_pkg::status_type status,
   output rtt_pkg::cmd_type    cmd
);

   rtt_pkg::state_type state_ff;
   rtt_pkg::state_type state_in;
   logic               accept;

   assign accept = req_valid && (state_ff == rtt_pkg::ST_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtt_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_command == rtt_pkg::CmdInit) ? rtt_pkg::ST_OUT_LD
                                                            : rtt_pkg::ST_SM_LO;
            end
         end
         rtt_pkg::ST_SM_LO:  state_in = rtt_pkg::ST_SM_HI;
         rtt_pkg::ST_SM_HI:  state_in = rtt_pkg::ST_SM_ACC;
         rtt_pkg::ST_SM_ACC: state_in = rtt_pkg::ST_SM_WR;
         rtt_pkg::ST_SM_WR:  state_in = rtt_pkg::ST_DV_LO;
         rtt_pkg::ST_DV_LO:  state_in = rtt_pkg::ST_DV_HI;
         rtt_pkg::ST_DV_HI:  state_in = rtt_pkg::ST_DV_ACC;
         rtt_pkg::ST_DV_ACC: state_in = rtt_pkg::ST_DV_WR;
         rtt_pkg::ST_DV_WR:  state_in = rtt_pkg::ST_TO_LO;
         rtt_pkg::ST_TO_LO:  state_in = rtt_pkg::ST_TO_HI;
         rtt_pkg::ST_TO_HI:  state_in = rtt_pkg::ST_TO_ACC;
         rtt_pkg::ST_TO_ACC: state_in = rtt_pkg::ST_TO_WR;
         rtt_pkg::ST_TO_WR:  state_in = rtt_pkg::ST_OUT_LD;
         rtt_pkg::ST_OUT_LD: begin
            if (status.out_free) begin
               state_in = rtt_pkg::ST_IDLE;
            end
         end
         default: state_in = rtt_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd             = '0;
      cmd.phase       = rtt_pkg::PH_SMOOTH;
      cmd.acc_op      = rtt_pkg::ACC_HOLD;
      req_stall       = (state_ff != rtt_pkg::ST_IDLE);
      unique case (state_ff)
         rtt_pkg::ST_IDLE: begin
            cmd.load_sample = accept;
            cmd.load_init   = accept && (req_command == rtt_pkg::CmdInit);
         end
         rtt_pkg::ST_SM_LO: begin
            cmd.acc_op = rtt_pkg::ACC_LOAD_ROUND;
         end
         rtt_pkg::ST_SM_HI: begin
            cmd.half_hi = 1'b1;
            cmd.acc_op  = rtt_pkg::ACC_ADD_LO;
         end
         rtt_pkg::ST_SM_ACC: cmd.acc_op = rtt_pkg::ACC_ADD_HI;
         rtt_pkg::ST_SM_WR:  cmd.wr_smooth = 1'b1;
         rtt_pkg::ST_DV_LO: begin
            cmd.phase  = rtt_pkg::PH_DEV;
            cmd.acc_op = rtt_pkg::ACC_LOAD_ROUND;
         end
         rtt_pkg::ST_DV_HI: begin
            cmd.phase   = rtt_pkg::PH_DEV;
            cmd.half_hi = 1'b1;
            cmd.acc_op  = rtt_pkg::ACC_ADD_LO;
         end
         rtt_pkg::ST_DV_ACC: begin
            cmd.phase  = rtt_pkg::PH_DEV;
            cmd.acc_op = rtt_pkg::ACC_ADD_HI;
         end
         rtt_pkg::ST_DV_WR: cmd.wr_dev = 1'b1;
         rtt_pkg::ST_TO_LO: begin
            cmd.phase  = rtt_pkg::PH_TIMEOUT;
            cmd.acc_op = rtt_pkg::ACC_LOAD_ROUND;
         end
         rtt_pkg::ST_TO_HI: begin
            cmd.phase   = rtt_pkg::PH_TIMEOUT;
            cmd.half_hi = 1'b1;
            cmd.acc_op  = rtt_pkg::ACC_ADD_LO;
         end
         rtt_pkg::ST_TO_ACC: begin
            cmd.phase  = rtt_pkg::PH_TIMEOUT;
            cmd.acc_op = rtt_pkg::ACC_ADD_HI;
         end
         rtt_pkg::ST_TO_WR:  cmd.wr_timeout = 1'b1;
         rtt_pkg::ST_OUT_LD: cmd.load_out = status.out_free;
         default: ;
      endcase
   end

endmodule

>>> sv/rtt_datapath.sv
// Weights, state, shared multipliers, accumulator and result register.
module rtt_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [rtt_pkg::IndexWidth-1:0]      csr_index,
   input  logic [rtt_pkg::WeightWidth-1:0]     csr_write_data,
   input  logic [rtt_pkg::SampleWidth-1:0]     req_sample_rtt,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [rtt_pkg::OutWidth-1:0]        rsp_timeout_value,
   output logic [rtt_pkg::OutWidth-1:0]        rsp_smoothed_rtt_out,
   output logic [rtt_pkg::OutWidth-1:0]        rsp_deviation_out,
   input  rtt_pkg::cmd_type                    cmd,
   output rtt_pkg::status_type                 status
);

   localparam int unsigned SW = rtt_pkg::StateWidth;
   localparam int unsigned HW = rtt_pkg::HalfWidth;
   localparam int unsigned WW = rtt_pkg::WeightWidth;
   localparam int unsigned PW = rtt_pkg::ProdWidth;
   localparam int unsigned AW = rtt_pkg::AccWidth;
   localparam int unsigned OW = rtt_pkg::OutWidth;

   // weight registers
   logic [WW-1:0] w_smooth_keep_ff, w_smooth_sample_ff, w_dev_keep_ff;
   logic [WW-1:0] w_dev_diff_ff, w_to_smooth_ff, w_to_dev_ff;

   // estimator state, Q32.8; the timeout is a whole number
   logic [SW-1:0] smooth_ff, dev_ff, diff_ff, sample_q_ff;
   logic [OW-1:0] timeout_ff;

   logic [PW-1:0] prod_a_ff, prod_b_ff;
   logic [AW-1:0] acc_ff;

   logic          rsp_valid_ff;
   logic [OW-1:0] rsp_timeout_ff, rsp_smooth_ff, rsp_dev_ff;

   logic [WW-1:0] wa, wb;
   logic [SW-1:0] opa, opb;
   logic [HW-1:0] opa_half, opb_half;
   logic [PW:0]   prod_sum;
   logic [AW-1:0] acc_in;
   logic [SW-1:0] sample_q, blend_sat, diff_in;
   logic [AW-13:0] blend_shift;
   logic [AW-21:0] to_shift;
   logic [OW-1:0] to_sat, smooth_us, dev_us;
   logic          out_free;

   // configuration writes; out-of-range indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         w_smooth_keep_ff   <= rtt_pkg::DefSmoothKeep;
         w_smooth_sample_ff <= rtt_pkg::DefSmoothSample;
         w_dev_keep_ff      <= rtt_pkg::DefDevKeep;
         w_dev_diff_ff      <= rtt_pkg::DefDevDiff;
         w_to_smooth_ff     <= rtt_pkg::DefTimeoutSmooth;
         w_to_dev_ff        <= rtt_pkg::DefTimeoutDev;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rtt_pkg::RegSmoothKeep:    w_smooth_keep_ff   <= csr_write_data;
            rtt_pkg::RegSmoothSample:  w_smooth_sample_ff <= csr_write_data;
            rtt_pkg::RegDevKeep:       w_dev_keep_ff      <= csr_write_data;
            rtt_pkg::RegDevDiff:       w_dev_diff_ff      <= csr_write_data;
            rtt_pkg::RegTimeoutSmooth: w_to_smooth_ff     <= csr_write_data;
            rtt_pkg::RegTimeoutDev:    w_to_dev_ff        <= csr_write_data;
            default: ;
         endcase
      end
   end

   // operand selection for the two multipliers
   always_comb begin
      unique case (cmd.phase)
         rtt_pkg::PH_SMOOTH: begin
            wa = w_smooth_keep_ff; opa = smooth_ff;
            wb = w_smooth_sample_ff; opb = sample_q_ff;
         end
         rtt_pkg::PH_DEV: begin
            wa = w_dev_keep_ff; opa = dev_ff;
            wb = w_dev_diff_ff; opb = diff_ff;
         end
         rtt_pkg::PH_TIMEOUT: begin
            wa = w_to_smooth_ff; opa = smooth_ff;
            wb = w_to_dev_ff; opb = dev_ff;
         end
         default: begin
            wa = w_smooth_keep_ff; opa = smooth_ff;
            wb = w_smooth_sample_ff; opb = sample_q_ff;
         end
      endcase
      opa_half = cmd.half_hi ? opa[SW-1:HW] : opa[HW-1:0];
      opb_half = cmd.half_hi ? opb[SW-1:HW] : opb[HW-1:0];
   end

   // 16x20 products, registered every cycle
   always_ff @(posedge clock) begin
      prod_a_ff <= PW'(wa) * PW'(opa_half);
      prod_b_ff <= PW'(wb) * PW'(opb_half);
   end

   assign prod_sum = {1'b0, prod_a_ff} + {1'b0, prod_b_ff};

   // accumulator
   always_comb begin
      acc_in = acc_ff;
      unique case (cmd.acc_op)
         rtt_pkg::ACC_HOLD:       acc_in = acc_ff;
         rtt_pkg::ACC_LOAD_ROUND: acc_in = (cmd.phase == rtt_pkg::PH_TIMEOUT)
                                           ? rtt_pkg::RoundTimeout : rtt_pkg::RoundState;
         rtt_pkg::ACC_ADD_LO:     acc_in = acc_ff + AW'(prod_sum);
         rtt_pkg::ACC_ADD_HI:     acc_in = acc_ff + AW'({prod_sum, {HW{1'b0}}});
         default:                 acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // rounding and saturation of the blended values
   assign sample_q    = {{(SW-rtt_pkg::SampleWidth-8){1'b0}}, req_sample_rtt, 8'd0};
   assign blend_shift = acc_ff[AW-1:12];
   assign blend_sat   = (|blend_shift[AW-13:SW]) ? {SW{1'b1}} : blend_shift[SW-1:0];
   assign diff_in     = (blend_sat >= sample_q_ff) ? blend_sat - sample_q_ff
                                                   : sample_q_ff - blend_sat;
   assign to_shift    = acc_ff[AW-1:20];
   assign to_sat      = (|to_shift[AW-21:OW]) ? {OW{1'b1}} : to_shift[OW-1:0];

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
         dev_ff    <= '0;
      end else if (cmd.load_init) begin
         smooth_ff <= sample_q;
         dev_ff    <= '0;
      end else begin
         if (cmd.wr_smooth) smooth_ff <= blend_sat;
         if (cmd.wr_dev)    dev_ff    <= blend_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) sample_q_ff <= sample_q;
      if (cmd.wr_smooth)   diff_ff     <= diff_in;
      if (cmd.load_init) begin
         timeout_ff <= OW'(req_sample_rtt);
      end else if (cmd.wr_timeout) begin
         timeout_ff <= to_sat;
      end
   end

   // Q32.8 to whole microseconds, ties up, saturated
   function automatic logic [rtt_pkg::OutWidth-1:0] to_micro(
      input logic [rtt_pkg::StateWidth-1:0] q
   );
      logic [rtt_pkg::StateWidth:0] sum;
      sum = {1'b0, q} + (rtt_pkg::StateWidth+1)'(128);
      return sum[rtt_pkg::StateWidth] ? {rtt_pkg::OutWidth{1'b1}}
                                      : sum[rtt_pkg::StateWidth-1:8];
   endfunction

   assign smooth_us = to_micro(smooth_ff);
   assign dev_us    = to_micro(dev_ff);

   // result register
   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign status.out_free = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_timeout_ff <= timeout_ff;
         rsp_smooth_ff  <= smooth_us;
         rsp_dev_ff     <= dev_us;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_timeout_value    = rsp_timeout_ff;
   assign rsp_smoothed_rtt_out = rsp_smooth_ff;
   assign rsp_deviation_out    = rsp_dev_ff;

endmodule

>>> sv/rtt_retransmit_timeout_estimator.sv
// RTT retransmit timeout estimator: one word in, one result word out.
// Update words pass three weighted blends before the next word can be accepted: each
// blend steps through LO, HI, ACC and WR states on two shared 16x20 multipliers.
// Initialise words skip the blends. Results appear in the cycle after the final load.
// A result waits in the output register; the next word is taken meanwhile.
// Synchronous reset clears smoothed RTT and deviation to zero and weights to defaults.
module rtt_retransmit_timeout_estimator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [rtt_pkg::SampleWidth-1:0]     req_sample_rtt,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rtt_pkg::OutWidth-1:0]        rsp_timeout_value,
   output logic [rtt_pkg::OutWidth-1:0]        rsp_smoothed_rtt_out,
   output logic [rtt_pkg::OutWidth-1:0]        rsp_deviation_out,
   input  logic                                csr_write_enable,
   input  logic [rtt_pkg::IndexWidth-1:0]      csr_index,
   input  logic [rtt_pkg::WeightWidth-1:0]     csr_write_data
);

   rtt_pkg::cmd_type    cmd;
   rtt_pkg::status_type status;

   // sequencer
   rtt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // arithmetic and storage
   rtt_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_sample_rtt       (req_sample_rtt),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_timeout_value    (rsp_timeout_value),
      .rsp_smoothed_rtt_out (rsp_smoothed_rtt_out),
      .rsp_deviation_out    (rsp_deviation_out),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule
